FILE: design/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg: shared types and constants for the tape machine executor
// Opcode and status codes, the decoded request format and the back end
// state encoding.
// ----------------------------------------------------------------------------
package tme_pkg;

	localparam int OP_W   = 3;
	localparam int ARG_W  = 29;
	localparam int PC_W   = 17;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 64;
	localparam int PTR_W  = 40;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_NEXT = 3'd0,
		OP_PREV = 3'd1,
		OP_INCR = 3'd2,
		OP_DECR = 3'd3,
		OP_PUTC = 3'd4,
		OP_GETC = 3'd5,
		OP_BEQZ = 3'd6,
		OP_BNEZ = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_RUN    = 2'd0,
		ST_DONE   = 2'd1,
		ST_TAPE   = 2'd2,
		ST_BRANCH = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_MOVE,
		K_ARITH,
		K_PUTC,
		K_GETC,
		K_BRANCH
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic                      negate;
		logic                      on_zero;
		logic [ARG_W-1:0]          arg;
		logic signed [ARG_W-1:0]   offset;
		logic [CHAR_W-1:0]         in_char;
		logic                      in_eof;
	} dec_req_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_ISSUE,
		BK_EXEC
	} bk_state_t;

endpackage

FILE: design/tme_ifs.sv
// ----------------------------------------------------------------------------
// tme_ifs: request and result channels of the tape machine executor
// Valid/ready channels carrying one bytecode word and one result.
// ----------------------------------------------------------------------------
interface tme_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [28:0] count_or_offset;
	logic [7:0]  in_char;
	logic        in_eof;

	modport source (output valid, opcode, count_or_offset, in_char, in_eof, input ready);
	modport sink   (input valid, opcode, count_or_offset, in_char, in_eof, output ready);
endinterface

interface tme_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] next_pc;
	logic [7:0]  out_char;
	logic [28:0] io_count;
	logic [1:0]  status;

	modport source (output valid, next_pc, out_char, io_count, status, input ready);
	modport sink   (input valid, next_pc, out_char, io_count, status, output ready);
endinterface

FILE: design/tme_front.sv
// ----------------------------------------------------------------------------
// tme_front: request intake and decode
// Accepts bytecode words, classifies the opcode, masks the argument and
// sign-extends the branch offset into one registered stage.
// ----------------------------------------------------------------------------
module tme_front import tme_pkg::*; #(
	parameter int ARG_BITS = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enable,
	tme_cmd_if.sink       cmd,
	output logic          push_valid,
	output dec_req_t      push_req,
	input  logic          push_ready
);

	localparam logic [ARG_W-1:0] ArgMask = ARG_W'((64'd1 << ARG_BITS) - 64'd1);
	localparam logic [ARG_W-1:0] SignBit = ARG_W'(64'd1 << (ARG_BITS - 1));

	logic          valid_s1;
	dec_req_t      req_s1;
	dec_req_t      dec;
	logic [ARG_W-1:0] arg_m;
	logic          take;

	assign cmd.ready = enable && (!valid_s1 || push_ready);
	assign take      = cmd.valid && cmd.ready;

	always_comb begin
		arg_m       = cmd.count_or_offset & ArgMask;
		dec.arg     = arg_m;
		dec.offset  = $signed((arg_m ^ SignBit) - SignBit);
		dec.in_char = cmd.in_char;
		dec.in_eof  = cmd.in_eof;
		dec.negate  = 1'b0;
		dec.on_zero = 1'b0;
		dec.kind    = K_MOVE;
		case (op_t'(cmd.opcode))
			OP_NEXT: dec.kind = K_MOVE;
			OP_PREV: begin
				dec.kind   = K_MOVE;
				dec.negate = 1'b1;
			end
			OP_INCR: dec.kind = K_ARITH;
			OP_DECR: begin
				dec.kind   = K_ARITH;
				dec.negate = 1'b1;
			end
			OP_PUTC: dec.kind = K_PUTC;
			OP_GETC: dec.kind = K_GETC;
			OP_BEQZ: begin
				dec.kind    = K_BRANCH;
				dec.on_zero = 1'b1;
			end
			OP_BNEZ: dec.kind = K_BRANCH;
			default: dec.kind = K_MOVE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= dec;
		end
	end

	assign push_valid = valid_s1;
	assign push_req   = req_s1;

endmodule

FILE: design/tme_queue.sv
// ----------------------------------------------------------------------------
// tme_queue: two-entry queue between decode and execute
// Lets the front and back stall independently.
// ----------------------------------------------------------------------------
module tme_queue import tme_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  dec_req_t push_req,
	output logic     push_ready,
	output logic     pop_valid,
	output dec_req_t pop_req,
	input  logic     pop_ready
);

	dec_req_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_req    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

FILE: design/tme_back.sv
// ----------------------------------------------------------------------------
// tme_back: execute stage with the tape memory
// Clears the tape after reset, then runs each request as a tape read
// followed by a read-modify-write, branch resolution and result register.
// ----------------------------------------------------------------------------
module tme_back import tme_pkg::*; #(
	parameter int TAPE_DEPTH    = 65536,
	parameter int PROGRAM_DEPTH = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [PC_W-1:0] program_length,
	input  logic            pop_valid,
	input  dec_req_t        pop_req,
	output logic            pop_ready,
	output logic            clear_done,
	tme_rsp_if.source       rsp
);

	localparam int AW = $clog2(TAPE_DEPTH);

	bk_state_t          state_q, state_n;
	logic [AW-1:0]      clr_idx_q;
	logic               clr_last;
	logic               clr_we;
	logic               exec_fire;
	logic               out_free;
	logic               rd_en;

	logic [CELL_W-1:0]  tape_mem [TAPE_DEPTH];
	logic [CELL_W-1:0]  rdata_q;
	logic               tape_we;
	logic [AW-1:0]      tape_waddr;
	logic [CELL_W-1:0]  tape_wdata;

	dec_req_t           req_q;
	logic [PTR_W-1:0]   dp_q, dp_n;
	logic [PC_W-1:0]    pc_q, pc_n;
	logic               halted_q, halted_n;
	status_t            halt_code_q, halt_code_n;

	logic               out_valid_q;
	logic [PC_W-1:0]    out_pc_q, res_pc;
	logic [CHAR_W-1:0]  out_char_q, res_char;
	logic [ARG_W-1:0]   out_cnt_q, res_cnt;
	status_t            out_st_q, res_st;

	logic [PC_W-1:0]    len;
	logic               in_range;
	logic               do_write;
	logic [CELL_W-1:0]  cell_wdata;
	logic               cell_zero;
	logic               br_take;
	logic               err;
	logic signed [31:0] dest;
	logic [PC_W-1:0]    next;

	assign clr_last   = (clr_idx_q == AW'(TAPE_DEPTH - 1));
	assign out_free   = !out_valid_q || rsp.ready;
	assign clear_done = (state_q != BK_CLEAR);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_CLEAR: if (clr_last) state_n = BK_ISSUE;
			BK_ISSUE: if (pop_valid) state_n = BK_EXEC;
			BK_EXEC:  if (out_free) state_n = BK_ISSUE;
			default:  state_n = BK_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		clr_we    = 1'b0;
		pop_ready = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			BK_CLEAR: clr_we = 1'b1;
			BK_ISSUE: pop_ready = 1'b1;
			BK_EXEC:  exec_fire = out_free;
			default:  clr_we = 1'b0;
		endcase
	end

	assign rd_en = pop_ready && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_n;
			if (clr_we) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
		end
	end

	// execute
	always_comb begin
		len = (32'(program_length) > 32'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH) : program_length;
		in_range   = (dp_q < PTR_W'(TAPE_DEPTH));
		cell_zero  = (rdata_q == '0);
		br_take    = req_q.on_zero ? cell_zero : !cell_zero;
		dest       = $signed(32'(pc_q)) + 32'sd1 + 32'(req_q.offset);
		dp_n       = dp_q;
		pc_n       = pc_q;
		halted_n   = halted_q;
		halt_code_n = halt_code_q;
		res_pc     = pc_q;
		res_char   = '0;
		res_cnt    = '0;
		res_st     = halt_code_q;
		do_write   = 1'b0;
		cell_wdata = rdata_q;
		err        = 1'b0;
		next       = pc_q + PC_W'(1);
		if (halted_q) begin
			res_st = halt_code_q;
		end else if (pc_q >= len) begin
			halted_n    = 1'b1;
			halt_code_n = ST_DONE;
			res_st      = ST_DONE;
		end else if (req_q.kind != K_MOVE && !in_range) begin
			halted_n    = 1'b1;
			halt_code_n = ST_TAPE;
			res_st      = ST_TAPE;
		end else begin
			case (req_q.kind)
				K_MOVE: begin
					dp_n = req_q.negate ? dp_q - PTR_W'(req_q.arg) : dp_q + PTR_W'(req_q.arg);
				end
				K_ARITH: begin
					do_write   = 1'b1;
					cell_wdata = req_q.negate ? rdata_q - CELL_W'(req_q.arg)
					                          : rdata_q + CELL_W'(req_q.arg);
				end
				K_PUTC: begin
					res_char = rdata_q[CHAR_W-1:0];
					res_cnt  = req_q.arg;
				end
				K_GETC: begin
					res_cnt    = req_q.arg;
					do_write   = (req_q.arg != '0);
					cell_wdata = req_q.in_eof ? '1 : CELL_W'(req_q.in_char);
				end
				K_BRANCH: begin
					if (br_take) begin
						if (dest < 0 || dest > $signed(32'(len))) begin
							err = 1'b1;
						end else begin
							next = dest[PC_W-1:0];
						end
					end
				end
				default: err = 1'b0;
			endcase
			if (err) begin
				halted_n    = 1'b1;
				halt_code_n = ST_BRANCH;
				res_st      = ST_BRANCH;
			end else begin
				pc_n   = next;
				res_pc = next;
				if (next >= len) begin
					halted_n    = 1'b1;
					halt_code_n = ST_DONE;
					res_st      = ST_DONE;
				end else begin
					res_st = ST_RUN;
				end
			end
		end
	end

	assign tape_we    = clr_we || (exec_fire && do_write);
	assign tape_waddr = clr_we ? clr_idx_q : dp_q[AW-1:0];
	assign tape_wdata = clr_we ? '0 : cell_wdata;

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		if (rd_en) begin
			rdata_q <= tape_mem[dp_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			req_q <= pop_req;
		end
		if (exec_fire) begin
			out_pc_q   <= res_pc;
			out_char_q <= res_char;
			out_cnt_q  <= res_cnt;
			out_st_q   <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q        <= '0;
			pc_q        <= '0;
			halted_q    <= 1'b0;
			halt_code_q <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				dp_q        <= dp_n;
				pc_q        <= pc_n;
				halted_q    <= halted_n;
				halt_code_q <= halt_code_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.next_pc  = out_pc_q;
	assign rsp.out_char = out_char_q;
	assign rsp.io_count = out_cnt_q;
	assign rsp.status   = out_st_q;

endmodule

FILE: design/tape_machine_bytecode_executor.sv
// ----------------------------------------------------------------------------
// tape_machine_bytecode_executor: run-length tape machine bytecode executor
// Issue: the back end takes a new request only after the previous one has left
// the execute stage: each request takes a tape read, then a read-modify-write.
// A request passes the front stage register, a queue entry, the tape read register
// and the result register. Reset: the tape is swept to zero, one cell a cycle;
// no request is accepted until the sweep ends. Config writes are taken always.
// ----------------------------------------------------------------------------
module tape_machine_bytecode_executor import tme_pkg::*; #(
	parameter int TAPE_DEPTH    = 65536,
	parameter int PROGRAM_DEPTH = 65536,
	parameter int ARG_BITS      = 29
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [PC_W-1:0] cfg_wdata,
	tme_cmd_if.sink         cmd,
	tme_rsp_if.source       rsp
);

	logic [PC_W-1:0] program_length_q;
	logic            clear_done;
	logic            f_valid;
	dec_req_t        f_req;
	logic            f_ready;
	logic            q_valid;
	dec_req_t        q_req;
	logic            q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= '0;
		end else if (cfg_we) begin
			program_length_q <= cfg_wdata;
		end
	end

	tme_front #(.ARG_BITS(ARG_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (clear_done),
		.cmd        (cmd),
		.push_valid (f_valid),
		.push_req   (f_req),
		.push_ready (f_ready)
	);

	tme_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_req   (f_req),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_req    (q_req),
		.pop_ready  (q_ready)
	);

	tme_back #(
		.TAPE_DEPTH    (TAPE_DEPTH),
		.PROGRAM_DEPTH (PROGRAM_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.program_length (program_length_q),
		.pop_valid      (q_valid),
		.pop_req        (q_req),
		.pop_ready      (q_ready),
		.clear_done     (clear_done),
		.rsp            (rsp)
	);

endmodule
